// ===== rtl/core/fmtpc_pkg.sv =====
// shared types, codes and sizes for the file metadata table with permission check
// no dependencies; the top level and the testbench refer to it by scoped names

package fmtpc_pkg;

   // table size and the index width that follows from it
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   // mode constants
   localparam logic [15:0] MODE_PERM_MASK = 16'o777;
   localparam logic [15:0] DEFAULT_MODE   = 16'o755;
   localparam logic [2:0]  ROOT_EXTRA     = 3'd6;

   // operation codes
   localparam logic [2:0] FUNC_WRITE  = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_RENAME = 3'd2;
   localparam logic [2:0] FUNC_QUERY  = 3'd3;
   localparam logic [2:0] FUNC_EXISTS = 3'd4;

   // control register indexes
   localparam logic [2:0] CSR_REAL_UID      = 3'd0;
   localparam logic [2:0] CSR_REAL_GID      = 3'd1;
   localparam logic [2:0] CSR_EFFECTIVE_UID = 3'd2;
   localparam logic [2:0] CSR_EFFECTIVE_GID = 3'd3;
   localparam logic [2:0] CSR_CREATE_MASK   = 3'd4;

   localparam logic [8:0] CREATE_MASK_RESET = 9'd18;

   // request beat
   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [63:0] new_key_high;
      logic [63:0] new_key_low;
      logic [15:0] file_mode;
      logic [31:0] owner_id;
      logic [31:0] group_id;
      logic        is_create;
      logic        use_real_ids;
   } req_type;

   // response beat
   typedef struct packed {
      logic        status;
      logic        found;
      logic [2:0]  perm_bits;
      logic [15:0] stored_mode;
      logic [31:0] stored_owner;
      logic [31:0] stored_group;
   } rsp_type;

   // one table record as kept in the record memory
   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [15:0] mode;
      logic [31:0] owner;
      logic [31:0] group;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/fmtpc_ram.sv =====
// generic single write port, single read port memory with registered read data
// no dependencies

module fmtpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/file_meta_table_perm_check.sv =====
// top level of the file metadata table with permission check
// depends on fmtpc_pkg and fmtpc_ram

// Each request beat (write, remove, rename, query, exists check) is taken at a rising edge
// with start high and busy low. The block then holds busy high while its sequencer walks
// the record memory through its single read port, one entry per cycle, looking for the
// key, the rename target and the lowest free entry at once. The fetch state then re-reads
// the matching record and the finish state completes the update; busy stays high through
// both, so no new beat is taken until the update is done. The response beat is shown on
// rsp_data for exactly one cycle with rsp_valid high; the receiver cannot stall it, so it
// must take every beat. A new start is taken in the same cycle that a response is shown.
// Entry valid bits sit in flip-flops cleared by reset, so no clearing pass runs after reset.
// Control registers may be written through the csr port whenever no request is in flight.

module file_meta_table_perm_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fmtpc_pkg::req_type req_data,
   output logic              rsp_valid,
   output fmtpc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [31:0]       csr_wdata
);

   // sequencer and request
   fmtpc_pkg::state_type state_ff, state_in;
   fmtpc_pkg::req_type   req_ff, req_in;
   logic [fmtpc_pkg::IDX_W-1:0] scan_ff, scan_in;

   // scan results
   logic                        hit_ff, hit_in;
   logic [fmtpc_pkg::IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic                        tgt_hit_ff, tgt_hit_in;
   logic [fmtpc_pkg::IDX_W-1:0] tgt_idx_ff, tgt_idx_in;
   logic                        free_hit_ff, free_hit_in;
   logic [fmtpc_pkg::IDX_W-1:0] free_idx_ff, free_idx_in;

   // entry valid bits
   logic [fmtpc_pkg::TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // control registers
   logic [31:0] real_uid_ff, real_gid_ff, eff_uid_ff, eff_gid_ff;
   logic [8:0]  create_mask_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   fmtpc_pkg::rsp_type rsp_ff, rsp_in;

   // record memory port signals
   logic                        ram_wr_en, ram_rd_en;
   logic [fmtpc_pkg::IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   fmtpc_pkg::rec_type          ram_wr_rec, ram_rd_rec;
   logic [fmtpc_pkg::REC_W-1:0] ram_rd_data;

   // compare unit and finish datapath
   logic        entry_live, key_hit, new_key_hit, start_ok, same_key;
   logic [15:0] wr_mode, q_mode;
   logic [31:0] q_owner, q_group, q_uid, q_gid;
   logic [2:0]  q_perm;

   fmtpc_ram #(
      .WIDTH (fmtpc_pkg::REC_W),
      .DEPTH (fmtpc_pkg::TABLE_ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_rec),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_rec = fmtpc_pkg::rec_type'(ram_rd_data);
   assign busy       = (state_ff != fmtpc_pkg::ST_IDLE);
   assign start_ok   = start && !busy;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // key compare against the entry read in the previous cycle
   assign entry_live  = valid_ff[scan_ff];
   assign key_hit     = entry_live && (ram_rd_rec.key_high == req_ff.key_high)
                        && (ram_rd_rec.key_low == req_ff.key_low);
   assign new_key_hit = entry_live && (ram_rd_rec.key_high == req_ff.new_key_high)
                        && (ram_rd_rec.key_low == req_ff.new_key_low);
   assign same_key    = (req_ff.key_high == req_ff.new_key_high)
                        && (req_ff.key_low == req_ff.new_key_low);

   // mode to store on write
   assign wr_mode = req_ff.is_create
                    ? (req_ff.file_mode & ~{7'd0, create_mask_ff} & fmtpc_pkg::MODE_PERM_MASK)
                    : req_ff.file_mode;

   // query record or defaults, and the granted bits
   assign q_mode  = hit_ff ? ram_rd_rec.mode  : fmtpc_pkg::DEFAULT_MODE;
   assign q_owner = hit_ff ? ram_rd_rec.owner : eff_uid_ff;
   assign q_group = hit_ff ? ram_rd_rec.group : eff_gid_ff;
   assign q_uid   = req_ff.use_real_ids ? real_uid_ff : eff_uid_ff;
   assign q_gid   = req_ff.use_real_ids ? real_gid_ff : eff_gid_ff;

   always_comb begin
      if ((q_uid == q_owner) || (q_uid == 32'd0)) begin
         q_perm = q_mode[8:6];
      end else if (q_gid == q_group) begin
         q_perm = q_mode[5:3];
      end else begin
         q_perm = q_mode[2:0];
      end
      if (q_uid == 32'd0) begin
         q_perm = q_perm | fmtpc_pkg::ROOT_EXTRA;
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmtpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         hit_ff       <= 1'b0;
         tgt_hit_ff   <= 1'b0;
         free_hit_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         hit_ff       <= hit_in;
         tgt_hit_ff   <= tgt_hit_in;
         free_hit_ff  <= free_hit_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      hit_idx_ff  <= hit_idx_in;
      tgt_idx_ff  <= tgt_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   // control registers written through the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         real_uid_ff    <= '0;
         real_gid_ff    <= '0;
         eff_uid_ff     <= '0;
         eff_gid_ff     <= '0;
         create_mask_ff <= fmtpc_pkg::CREATE_MASK_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            fmtpc_pkg::CSR_REAL_UID:      real_uid_ff    <= csr_wdata;
            fmtpc_pkg::CSR_REAL_GID:      real_gid_ff    <= csr_wdata;
            fmtpc_pkg::CSR_EFFECTIVE_UID: eff_uid_ff     <= csr_wdata;
            fmtpc_pkg::CSR_EFFECTIVE_GID: eff_gid_ff     <= csr_wdata;
            fmtpc_pkg::CSR_CREATE_MASK:   create_mask_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // next state, scan bookkeeping, table update and response
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      tgt_hit_in   = tgt_hit_ff;
      tgt_idx_in   = tgt_idx_ff;
      free_hit_in  = free_hit_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_ff + fmtpc_pkg::IDX_W'(1);
      ram_wr_en    = 1'b0;
      ram_wr_addr  = hit_idx_ff;
      ram_wr_rec   = ram_rd_rec;

      unique case (state_ff)
         fmtpc_pkg::ST_IDLE: begin
            // take the beat and read entry zero
            if (start_ok) begin
               req_in      = req_data;
               scan_in     = '0;
               hit_in      = 1'b0;
               tgt_hit_in  = 1'b0;
               free_hit_in = 1'b0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = fmtpc_pkg::ST_SCAN;
            end
         end

         fmtpc_pkg::ST_SCAN: begin
            // first match of key, target key and free entry
            if (!hit_ff && key_hit) begin
               hit_in     = 1'b1;
               hit_idx_in = scan_ff;
            end
            if (!tgt_hit_ff && new_key_hit) begin
               tgt_hit_in = 1'b1;
               tgt_idx_in = scan_ff;
            end
            if (!free_hit_ff && !entry_live) begin
               free_hit_in = 1'b1;
               free_idx_in = scan_ff;
            end
            if (scan_ff == fmtpc_pkg::IDX_W'(fmtpc_pkg::TABLE_ENTRIES - 1)) begin
               state_in = fmtpc_pkg::ST_FETCH;
            end else begin
               ram_rd_en = 1'b1;
               scan_in   = scan_ff + fmtpc_pkg::IDX_W'(1);
            end
         end

         fmtpc_pkg::ST_FETCH: begin
            // re-read the matching record
            ram_rd_en   = 1'b1;
            ram_rd_addr = hit_idx_ff;
            state_in    = fmtpc_pkg::ST_FINISH;
         end

         fmtpc_pkg::ST_FINISH: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            state_in     = fmtpc_pkg::ST_IDLE;
            case (req_ff.func)
               fmtpc_pkg::FUNC_WRITE: begin
                  ram_wr_rec.key_high = req_ff.key_high;
                  ram_wr_rec.key_low  = req_ff.key_low;
                  ram_wr_rec.mode     = wr_mode;
                  ram_wr_rec.owner    = req_ff.owner_id;
                  ram_wr_rec.group    = req_ff.group_id;
                  if (hit_ff || free_hit_ff) begin
                     ram_wr_en = 1'b1;
                     if (!hit_ff) begin
                        ram_wr_addr           = free_idx_ff;
                        valid_in[free_idx_ff] = 1'b1;
                     end
                     rsp_in.found        = hit_ff;
                     rsp_in.stored_mode  = wr_mode;
                     rsp_in.stored_owner = req_ff.owner_id;
                     rsp_in.stored_group = req_ff.group_id;
                  end else begin
                     rsp_in.status = 1'b1;
                  end
               end
               fmtpc_pkg::FUNC_REMOVE: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end
                  rsp_in.found = hit_ff;
               end
               fmtpc_pkg::FUNC_RENAME: begin
                  // drop any record at the target key, then rekey in place
                  if (hit_ff && !same_key) begin
                     if (tgt_hit_ff) begin
                        valid_in[tgt_idx_ff] = 1'b0;
                     end
                     ram_wr_en           = 1'b1;
                     ram_wr_rec.key_high = req_ff.new_key_high;
                     ram_wr_rec.key_low  = req_ff.new_key_low;
                  end
                  rsp_in.found = hit_ff;
               end
               fmtpc_pkg::FUNC_QUERY: begin
                  rsp_in.found        = hit_ff;
                  rsp_in.perm_bits    = q_perm;
                  rsp_in.stored_mode  = q_mode;
                  rsp_in.stored_owner = q_owner;
                  rsp_in.stored_group = q_group;
               end
               fmtpc_pkg::FUNC_EXISTS: begin
                  rsp_in.found = hit_ff;
               end
               default: ;
            endcase
         end

         default: state_in = fmtpc_pkg::ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   // a response beat only follows the finishing step
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == fmtpc_pkg::ST_FINISH))
      else $error("response beat without a finishing step");

   // an accepted beat starts the scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      start_ok |=> (state_ff == fmtpc_pkg::ST_SCAN) && (scan_ff == '0))
      else $error("accepted beat did not start the scan");

   // the scan ends after the last entry
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fmtpc_pkg::ST_SCAN)
      && (scan_ff == fmtpc_pkg::IDX_W'(fmtpc_pkg::TABLE_ENTRIES - 1))
      |=> (state_ff == fmtpc_pkg::ST_FETCH))
      else $error("scan did not end at the last entry");

   // table full is reported only when every entry was valid
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status |-> $past(&valid_ff) && !rsp_ff.found)
      else $error("table full reported with a free entry");
`endif

endmodule

// ===== sim/file_meta_table_perm_check_test.sv =====
// self-checking testbench for the file metadata table with permission check
// depends on fmtpc_pkg and the file_meta_table_perm_check rtl; needs no files or arguments

`timescale 1ns / 100ps

module file_meta_table_perm_check_test;

   localparam int KEY_POOL      = 24;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 40;
   localparam int QUIET_LIMIT   = 1000;

   typedef enum logic [1:0] {
      OP_BEAT,
      OP_CSR,
      OP_SETTLE
   } op_kind_type;

   typedef struct {
      op_kind_type        kind;
      fmtpc_pkg::req_type beat;
      logic [2:0]         csr_index;
      logic [31:0]        csr_value;
   } stim_op_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   fmtpc_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   fmtpc_pkg::rsp_type rsp_data;
   logic               csr_we    = 1'b0;
   logic [2:0]         csr_addr  = '0;
   logic [31:0]        csr_wdata = '0;

   // stimulus and expected responses
   stim_op_type        pending_ops[$];
   fmtpc_pkg::rsp_type expected_rsp[$];
   int          beats_queued   = 0;
   int          beats_accepted = 0;
   int          mismatches     = 0;
   int          gap_left       = 0;
   int          burst_left     = 0;
   int          settle_cnt     = 0;
   int          quiet_cycles   = 0;

   // shadow of the record table and control registers
   logic        tbl_valid     [fmtpc_pkg::TABLE_ENTRIES];
   logic [63:0] tbl_key_high  [fmtpc_pkg::TABLE_ENTRIES];
   logic [63:0] tbl_key_low   [fmtpc_pkg::TABLE_ENTRIES];
   logic [15:0] tbl_mode      [fmtpc_pkg::TABLE_ENTRIES];
   logic [31:0] tbl_owner     [fmtpc_pkg::TABLE_ENTRIES];
   logic [31:0] tbl_group     [fmtpc_pkg::TABLE_ENTRIES];
   logic [31:0] cfg_real_uid, cfg_real_gid, cfg_eff_uid, cfg_eff_gid;
   logic [8:0]  cfg_create_mask;

   // ids the generator aims owners and groups at in the current phase
   logic [31:0] gen_real_uid = '0, gen_real_gid = '0, gen_eff_uid = '0, gen_eff_gid = '0;
   logic [127:0] key_pool [KEY_POOL];

   file_meta_table_perm_check uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // table search helpers
   function automatic int find_key(input logic [63:0] kh, input logic [63:0] kl);
      for (int i = 0; i < fmtpc_pkg::TABLE_ENTRIES; i++)
         if (tbl_valid[i] && tbl_key_high[i] == kh && tbl_key_low[i] == kl)
            return i;
      return -1;
   endfunction

   function automatic int first_free();
      for (int i = 0; i < fmtpc_pkg::TABLE_ENTRIES; i++)
         if (!tbl_valid[i])
            return i;
      return -1;
   endfunction

   // apply one request beat to the shadow table and return the response it yields
   function automatic fmtpc_pkg::rsp_type apply_table_op(input fmtpc_pkg::req_type b);
      fmtpc_pkg::rsp_type r;
      int          hit, slot, tgt;
      logic [15:0] m;
      logic [31:0] own, grp, uid, gid;
      logic [2:0]  perm;
      r = '0;
      hit = find_key(b.key_high, b.key_low);
      case (b.func)
         fmtpc_pkg::FUNC_WRITE: begin
            slot = hit;
            if (hit >= 0)
               r.found = 1'b1;
            else
               slot = first_free();
            if (slot < 0) begin
               r.status = 1'b1;
            end else begin
               m = b.file_mode;
               if (b.is_create)
                  m = m & ~{7'd0, cfg_create_mask} & fmtpc_pkg::MODE_PERM_MASK;
               tbl_valid[slot]    = 1'b1;
               tbl_key_high[slot] = b.key_high;
               tbl_key_low[slot]  = b.key_low;
               tbl_mode[slot]     = m;
               tbl_owner[slot]    = b.owner_id;
               tbl_group[slot]    = b.group_id;
               r.stored_mode      = m;
               r.stored_owner     = b.owner_id;
               r.stored_group     = b.group_id;
            end
         end
         fmtpc_pkg::FUNC_REMOVE: begin
            if (hit >= 0) begin
               tbl_valid[hit] = 1'b0;
               r.found = 1'b1;
            end
         end
         fmtpc_pkg::FUNC_RENAME: begin
            if (hit >= 0) begin
               r.found = 1'b1;
               if (b.key_high != b.new_key_high || b.key_low != b.new_key_low) begin
                  // an existing record at the target key is replaced
                  tgt = find_key(b.new_key_high, b.new_key_low);
                  if (tgt >= 0)
                     tbl_valid[tgt] = 1'b0;
                  tbl_key_high[hit] = b.new_key_high;
                  tbl_key_low[hit]  = b.new_key_low;
               end
            end
         end
         fmtpc_pkg::FUNC_QUERY: begin
            if (hit >= 0) begin
               r.found = 1'b1;
               m   = tbl_mode[hit];
               own = tbl_owner[hit];
               grp = tbl_group[hit];
            end else begin
               m   = fmtpc_pkg::DEFAULT_MODE;
               own = cfg_eff_uid;
               grp = cfg_eff_gid;
            end
            uid = b.use_real_ids ? cfg_real_uid : cfg_eff_uid;
            gid = b.use_real_ids ? cfg_real_gid : cfg_eff_gid;
            // owner digit, then group digit, then other; root always reads and writes
            if (uid == own || uid == 0)
               perm = m[8:6];
            else if (gid == grp)
               perm = m[5:3];
            else
               perm = m[2:0];
            if (uid == 0)
               perm = perm | fmtpc_pkg::ROOT_EXTRA;
            r.perm_bits    = perm;
            r.stored_mode  = m;
            r.stored_owner = own;
            r.stored_group = grp;
         end
         fmtpc_pkg::FUNC_EXISTS: r.found = (hit >= 0);
         default: ;
      endcase
      return r;
   endfunction

   function automatic void set_cfg(input logic [2:0] index, input logic [31:0] value);
      case (index)
         fmtpc_pkg::CSR_REAL_UID:      cfg_real_uid    = value;
         fmtpc_pkg::CSR_REAL_GID:      cfg_real_gid    = value;
         fmtpc_pkg::CSR_EFFECTIVE_UID: cfg_eff_uid     = value;
         fmtpc_pkg::CSR_EFFECTIVE_GID: cfg_eff_gid     = value;
         fmtpc_pkg::CSR_CREATE_MASK:   cfg_create_mask = value[8:0];
         default: ;
      endcase
   endfunction

   // idle length before the next beat: mostly short, a few long, some bursts with none
   function automatic int pick_gap();
      int r;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 40)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 20);
      return $urandom_range(30, 120);
   endfunction

   // driver: issues beats, control writes and settle points from the pending queue
   always @(posedge clock) begin : drive
      logic nxt_start;
      logic nxt_we;
      if (reset) begin
         start           <= 1'b0;
         csr_we          <= 1'b0;
         gap_left        = 0;
         settle_cnt      = 0;
         cfg_real_uid    = '0;
         cfg_real_gid    = '0;
         cfg_eff_uid     = '0;
         cfg_eff_gid     = '0;
         cfg_create_mask = fmtpc_pkg::CREATE_MASK_RESET;
         for (int i = 0; i < fmtpc_pkg::TABLE_ENTRIES; i++)
            tbl_valid[i] = 1'b0;
      end else begin
         nxt_start = start;
         nxt_we    = 1'b0;
         if (start && !busy) begin
            expected_rsp.push_back(apply_table_op(req_data));
            beats_accepted++;
            nxt_start = 1'b0;
            gap_left  = pick_gap();
         end
         if (!nxt_start && pending_ops.size() != 0) begin
            if (gap_left != 0) begin
               gap_left--;
            end else begin
               case (pending_ops[0].kind)
                  OP_BEAT: begin
                     nxt_start = 1'b1;
                     req_data  <= pending_ops[0].beat;
                     void'(pending_ops.pop_front());
                  end
                  OP_CSR: begin
                     nxt_we    = 1'b1;
                     csr_addr  <= pending_ops[0].csr_index;
                     csr_wdata <= pending_ops[0].csr_value;
                     set_cfg(pending_ops[0].csr_index, pending_ops[0].csr_value);
                     void'(pending_ops.pop_front());
                  end
                  default: begin
                     // hold off until every response is in and the block is idle
                     if (expected_rsp.size() != 0 || busy) begin
                        settle_cnt = 0;
                     end else if (settle_cnt == SETTLE_CYCLES) begin
                        settle_cnt = 0;
                        void'(pending_ops.pop_front());
                     end else begin
                        settle_cnt++;
                     end
                  end
               endcase
            end
         end
         start  <= nxt_start;
         csr_we <= nxt_we;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // monitor: every response beat is checked against the oldest expectation
   always @(posedge clock) begin : watch_rsp
      fmtpc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual %h",
                     $time, rsp_data);
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("found", 32'(want.found), 32'(rsp_data.found));
            check_field("perm_bits", 32'(want.perm_bits), 32'(rsp_data.perm_bits));
            check_field("stored_mode", 32'(want.stored_mode), 32'(rsp_data.stored_mode));
            check_field("stored_owner", want.stored_owner, rsp_data.stored_owner);
            check_field("stored_group", want.stored_group, rsp_data.stored_group);
         end
      end
   end

   // watchdog on cycles with no beat, response or control write
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus builders
   task automatic add_beat(input fmtpc_pkg::req_type b);
      stim_op_type op;
      op = '{kind: OP_BEAT, beat: b, csr_index: '0, csr_value: '0};
      pending_ops.push_back(op);
      beats_queued++;
   endtask

   task automatic add_settle();
      stim_op_type op;
      op = '{kind: OP_SETTLE, beat: '0, csr_index: '0, csr_value: '0};
      pending_ops.push_back(op);
   endtask

   task automatic add_csr(input logic [2:0] index, input logic [31:0] value);
      stim_op_type op;
      op = '{kind: OP_CSR, beat: '0, csr_index: index, csr_value: value};
      pending_ops.push_back(op);
   endtask

   task automatic add_setting(input logic [31:0] ruid, input logic [31:0] rgid,
                              input logic [31:0] euid, input logic [31:0] egid,
                              input logic [8:0] mask);
      add_settle();
      add_csr(fmtpc_pkg::CSR_REAL_UID, ruid);
      add_csr(fmtpc_pkg::CSR_REAL_GID, rgid);
      add_csr(fmtpc_pkg::CSR_EFFECTIVE_UID, euid);
      add_csr(fmtpc_pkg::CSR_EFFECTIVE_GID, egid);
      add_csr(fmtpc_pkg::CSR_CREATE_MASK, {23'd0, mask});
      gen_real_uid = ruid;
      gen_real_gid = rgid;
      gen_eff_uid  = euid;
      gen_eff_gid  = egid;
   endtask

   function automatic fmtpc_pkg::req_type dir_beat(input logic [2:0] func,
                                        input logic [127:0] key,
                                        input logic [127:0] new_key,
                                        input logic [15:0] mode, input logic [31:0] owner,
                                        input logic [31:0] group, input logic create,
                                        input logic real_ids);
      fmtpc_pkg::req_type b;
      b.func         = func;
      b.key_high     = key[127:64];
      b.key_low      = key[63:0];
      b.new_key_high = new_key[127:64];
      b.new_key_low  = new_key[63:0];
      b.file_mode    = mode;
      b.owner_id     = owner;
      b.group_id     = group;
      b.is_create    = create;
      b.use_real_ids = real_ids;
      return b;
   endfunction

   // keys mostly from a small pool so hits, renames onto live keys and a full table occur
   function automatic logic [127:0] pick_key();
      if ($urandom_range(0, 9) == 0)
         return {$urandom, $urandom, $urandom, $urandom};
      return key_pool[$urandom_range(0, KEY_POOL - 1)];
   endfunction

   function automatic logic [31:0] pick_id(input logic [31:0] id_a, input logic [31:0] id_b);
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return id_a;
      if (r < 6)
         return id_b;
      if (r == 6)
         return '0;
      if (r == 7)
         return '1;
      return $urandom;
   endfunction

   function automatic fmtpc_pkg::req_type random_beat();
      fmtpc_pkg::req_type b;
      int           r;
      logic [127:0] key, new_key;
      r = $urandom_range(0, 99);
      if (r < 34)
         b.func = fmtpc_pkg::FUNC_WRITE;
      else if (r < 46)
         b.func = fmtpc_pkg::FUNC_REMOVE;
      else if (r < 60)
         b.func = fmtpc_pkg::FUNC_RENAME;
      else if (r < 84)
         b.func = fmtpc_pkg::FUNC_QUERY;
      else if (r < 97)
         b.func = fmtpc_pkg::FUNC_EXISTS;
      else
         b.func = 3'($urandom_range(5, 7));
      key = pick_key();
      new_key = ($urandom_range(0, 9) == 0) ? key : pick_key();
      b.key_high     = key[127:64];
      b.key_low      = key[63:0];
      b.new_key_high = new_key[127:64];
      b.new_key_low  = new_key[63:0];
      b.file_mode    = 16'($urandom);
      b.owner_id     = pick_id(gen_real_uid, gen_eff_uid);
      b.group_id     = pick_id(gen_real_gid, gen_eff_gid);
      b.is_create    = 1'($urandom_range(0, 1));
      b.use_real_ids = 1'($urandom_range(0, 1));
      return b;
   endfunction

   task automatic add_random(input int count);
      repeat (count) begin
         add_beat(random_beat());
         if ($urandom_range(0, 49) == 0)
            add_settle();
      end
   endtask

   initial begin : stimulus
      logic [127:0] k0, k1, k2, k_miss;
      logic [31:0]  u, g;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++)
         key_pool[i] = {$urandom, $urandom, $urandom, $urandom};
      k0 = key_pool[0];
      k1 = key_pool[1];
      k2 = key_pool[2];
      k_miss = {$urandom, $urandom, $urandom, $urandom};

      // directed part under reset settings: root ids, umask 022
      add_beat(dir_beat(fmtpc_pkg::FUNC_QUERY, k0, k0, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_EXISTS, k0, k0, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_REMOVE, k0, k0, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_RENAME, k0, k1, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_WRITE, k0, k0, '1, '0, '0, 1'b1, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_QUERY, k0, k0, '0, '0, '0, 1'b0, 1'b1));
      add_beat(dir_beat(fmtpc_pkg::FUNC_WRITE, k0, k1, '0, '1, '1, 1'b0, 1'b1));
      add_beat(dir_beat(fmtpc_pkg::FUNC_QUERY, k0, k0, '0, '0, '0, 1'b0, 1'b1));
      add_beat(dir_beat(fmtpc_pkg::FUNC_EXISTS, k0, k0, '1, '1, '1, 1'b1, 1'b1));
      add_beat(dir_beat(fmtpc_pkg::FUNC_WRITE, k1, k0, '1, '1, '1, 1'b0, 1'b0));
      // rename onto itself, then onto a live key which gets replaced
      add_beat(dir_beat(fmtpc_pkg::FUNC_RENAME, k0, k0, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_RENAME, k0, k1, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_EXISTS, k0, k0, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_QUERY, k1, k1, '0, '0, '0, 1'b0, 1'b0));
      // rename to a free key, then remove it twice
      add_beat(dir_beat(fmtpc_pkg::FUNC_RENAME, k1, k2, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_QUERY, k2, k2, '0, '0, '0, 1'b0, 1'b1));
      add_beat(dir_beat(fmtpc_pkg::FUNC_REMOVE, k2, k2, '0, '0, '0, 1'b0, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_REMOVE, k2, k2, '0, '0, '0, 1'b0, 1'b0));
      // undefined operation codes
      add_beat(dir_beat(3'd5, k0, k0, '1, '1, '1, 1'b1, 1'b1));
      add_beat(dir_beat(3'd6, k1, k1, '1, '1, '1, 1'b0, 1'b0));
      add_beat(dir_beat(3'd7, k_miss, k1, '1, '1, '1, 1'b1, 1'b0));
      add_beat(dir_beat(fmtpc_pkg::FUNC_QUERY, k_miss, k_miss, '0, '0, '0, 1'b0, 1'b1));

      // ordinary users, no umask
      add_setting(32'd1000, 32'd100, 32'd1001, 32'd101, 9'd0);
      add_random(130);

      // all-ones real ids, root effective ids, full umask; the table is filled first
      add_setting('1, '1, '0, '0, 9'h1FF);
      for (int i = 0; i < KEY_POOL; i++)
         add_beat(dir_beat(fmtpc_pkg::FUNC_WRITE, key_pool[i], key_pool[i], 16'($urandom),
                           pick_id(gen_real_uid, gen_eff_uid),
                           pick_id(gen_real_gid, gen_eff_gid),
                           1'($urandom_range(0, 1)), 1'b0));
      add_random(130);

      // random ids and umask
      add_setting($urandom, $urandom, $urandom, $urandom, 9'($urandom_range(0, 511)));
      add_random(130);

      // real and effective ids equal, reset umask
      u = $urandom_range(1, 60000);
      g = $urandom_range(1, 60000);
      add_setting(u, g, u, g, fmtpc_pkg::CREATE_MASK_RESET);
      add_random(130);

      // release reset, wait for every beat and response, then let things settle
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (beats_accepted != beats_queued || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
